// ----- sv/gcd_pkg.sv -----
// Shared types, fixed-point widths and constants for the great-circle distance core.
// Depends on nothing; every other file refers to it by scoped names.
package gcd_pkg;

    localparam int CW = 25;
    localparam int XW = 33;
    localparam int ZW = 34;
    localparam int DW = 32;
    localparam int VW = 61;
    localparam int RW = 62;
    localparam int FW = 31;
    localparam int SQ_STEPS = 31;
    localparam int DIST_W = 23;

    localparam int LANES = 3;
    localparam int LANE_LAT_A = 0;
    localparam int LANE_LAT_B = 1;
    localparam int LANE_DLON = 2;

    localparam logic [1:0] UNIT_KM = 2'd1;
    localparam logic [1:0] UNIT_NM = 2'd2;

    localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
    localparam longint unsigned PI_Q30 = (PI_Q60 + (64'd1 << 29)) >> 30;
    localparam longint unsigned DEG2RAD_Q36 = (PI_Q60 / 180 + (64'd1 << 23)) >> 24;
    localparam longint unsigned MI_DEN = 5 * PI_Q30;
    localparam longint unsigned F_MI = ((64'd62181 << 48) + MI_DEN / 2) / MI_DEN;
    localparam longint unsigned F_KM = (F_MI * 64'd1609344 + 64'd500000) / 64'd1000000;
    localparam longint unsigned F_NM = (F_MI * 64'd8684 + 64'd5000) / 64'd10000;

    typedef logic signed [XW-1:0] t_trig;
    typedef logic signed [ZW-1:0] t_angle;

    localparam t_trig INV_GAIN_Q30 = t_trig'(652032874);
    localparam t_angle HALF_PI_Q30 = t_angle'(PI_Q30 >> 1);
    localparam logic signed [DW-1:0] ONE_Q30 = DW'(64'd1 << 30);
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic       vld;
        logic       ok;
        logic [1:0] unit;
    } t_side;

    function automatic logic [30:0] atan_q30(input int idx);
        logic [30:0] v;
        case (idx)
            0: v = 31'd843314857;
            1: v = 31'd497837829;
            2: v = 31'd263043837;
            3: v = 31'd133525159;
            4: v = 31'd67021687;
            5: v = 31'd33543516;
            6: v = 31'd16775851;
            7: v = 31'd8388437;
            8: v = 31'd4194283;
            9: v = 31'd2097149;
            31: v = 31'd1;
            default: v = (idx >= 0 && idx <= 30) ? 31'(64'd1 << (30 - idx)) : '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/gcd_front.sv -----
// Input stage: coordinate range check, longitude difference folding, degree to radian.
// Two register stages; depends on gcd_pkg.
module gcd_front #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [gcd_pkg::CW-1:0]     i_lat_a,
    input  logic signed [gcd_pkg::CW-1:0]     i_lon_a,
    input  logic signed [gcd_pkg::CW-1:0]     i_lat_b,
    input  logic signed [gcd_pkg::CW-1:0]     i_lon_b,
    input  logic [1:0]                        i_unit_sel,
    output gcd_pkg::t_angle                   o_z [gcd_pkg::LANES],
    output logic                              o_neg,
    output gcd_pkg::t_side                    o_side
);
    localparam int AW = 36;
    localparam int TW = 26;
    localparam int PW = TW + 31;
    localparam int ZW = gcd_pkg::ZW;
    localparam int SH = ANGLE_FRAC_BITS + 6;
    localparam logic signed [AW-1:0] D90 = AW'(64'd90 << ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] D180 = AW'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] D360 = AW'(64'd360 << ANGLE_FRAC_BITS);
    localparam logic signed [PW-1:0] RND = PW'(64'd1 << (SH - 1));
    localparam logic signed [PW-1:0] K = PW'(gcd_pkg::DEG2RAD_Q36);

    logic signed [AW-1:0] w_lat_a, w_lon_a, w_lat_b, w_lon_b;
    logic signed [AW-1:0] w_dif, w_abs, w_wrap, w_t;
    logic                 w_ok, w_neg;
    logic signed [PW-1:0] w_rnd [gcd_pkg::LANES];

    logic signed [TW-1:0] r_ang [gcd_pkg::LANES];
    logic                 r_neg1;
    gcd_pkg::t_side       r_side1;
    gcd_pkg::t_angle      r_z [gcd_pkg::LANES];
    logic                 r_neg2;
    gcd_pkg::t_side       r_side2;

    always_comb begin
        w_lat_a = AW'(i_lat_a);
        w_lon_a = AW'(i_lon_a);
        w_lat_b = AW'(i_lat_b);
        w_lon_b = AW'(i_lon_b);
        w_ok = (w_lat_a <= D90) && (w_lat_a >= -D90) && (w_lat_b <= D90) && (w_lat_b >= -D90)
            && (w_lon_a <= D180) && (w_lon_a >= -D180) && (w_lon_b <= D180)
            && (w_lon_b >= -D180);
        w_dif = w_lon_a - w_lon_b;
        w_abs = w_dif[AW-1] ? -w_dif : w_dif;
        w_wrap = (w_abs > D180) ? D360 - w_abs : w_abs;
        w_neg = w_wrap > D90;
        w_t = w_neg ? D180 - w_wrap : w_wrap;
    end

    always_comb begin
        for (int k = 0; k < gcd_pkg::LANES; k++) begin
            w_rnd[k] = PW'(r_ang[k]) * K + RND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1 <= '0;
            r_side2 <= '0;
        end else if (i_en) begin
            r_side1 <= '{vld: i_valid, ok: w_ok, unit: i_unit_sel};
            r_side2 <= r_side1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang[gcd_pkg::LANE_LAT_A] <= TW'(i_lat_a);
            r_ang[gcd_pkg::LANE_LAT_B] <= TW'(i_lat_b);
            r_ang[gcd_pkg::LANE_DLON] <= TW'(w_t);
            r_neg1 <= w_neg;
            for (int k = 0; k < gcd_pkg::LANES; k++) begin
                r_z[k] <= ZW'(w_rnd[k] >>> SH);
            end
            r_neg2 <= r_neg1;
        end
    end

    assign o_z = r_z;
    assign o_neg = r_neg2;
    assign o_side = r_side2;

endmodule

// ----- sv/gcd_trig.sv -----
// Three-lane unrolled rotation CORDIC giving cos and sin, one register stage per iteration.
// Depends on gcd_pkg.
module gcd_trig #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  gcd_pkg::t_angle i_z [gcd_pkg::LANES],
    input  logic            i_neg,
    input  gcd_pkg::t_side  i_side,
    output gcd_pkg::t_trig  o_cos [gcd_pkg::LANES],
    output gcd_pkg::t_trig  o_sin [gcd_pkg::LANES],
    output logic            o_neg,
    output gcd_pkg::t_side  o_side
);
    localparam int N = CORDIC_STAGES;
    localparam int ZW = gcd_pkg::ZW;

    gcd_pkg::t_trig  r_x [N][gcd_pkg::LANES];
    gcd_pkg::t_trig  r_y [N][gcd_pkg::LANES];
    gcd_pkg::t_angle r_z [N][gcd_pkg::LANES];
    logic            r_neg [N];
    gcd_pkg::t_side  r_side [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        localparam gcd_pkg::t_angle ATAN = gcd_pkg::t_angle'(gcd_pkg::atan_q30(s));
        gcd_pkg::t_trig  w_x [gcd_pkg::LANES];
        gcd_pkg::t_trig  w_y [gcd_pkg::LANES];
        gcd_pkg::t_angle w_z [gcd_pkg::LANES];
        logic            w_neg;
        gcd_pkg::t_side  w_side;

        if (s == 0) begin : g_src
            always_comb begin
                for (int k = 0; k < gcd_pkg::LANES; k++) begin
                    w_x[k] = gcd_pkg::INV_GAIN_Q30;
                    w_y[k] = '0;
                    w_z[k] = i_z[k];
                end
                w_neg = i_neg;
                w_side = i_side;
            end
        end else begin : g_src
            always_comb begin
                for (int k = 0; k < gcd_pkg::LANES; k++) begin
                    w_x[k] = r_x[s-1][k];
                    w_y[k] = r_y[s-1][k];
                    w_z[k] = r_z[s-1][k];
                end
                w_neg = r_neg[s-1];
                w_side = r_side[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s] <= '0;
            end else if (i_en) begin
                r_side[s] <= w_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[s] <= w_neg;
                for (int k = 0; k < gcd_pkg::LANES; k++) begin
                    if (!w_z[k][ZW-1]) begin
                        r_x[s][k] <= w_x[k] - (w_y[k] >>> s);
                        r_y[s][k] <= w_y[k] + (w_x[k] >>> s);
                        r_z[s][k] <= w_z[k] - ATAN;
                    end else begin
                        r_x[s][k] <= w_x[k] + (w_y[k] >>> s);
                        r_y[s][k] <= w_y[k] - (w_x[k] >>> s);
                        r_z[s][k] <= w_z[k] + ATAN;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < gcd_pkg::LANES; k++) begin
            o_cos[k] = r_x[N-1][k];
            o_sin[k] = r_y[N-1][k];
        end
    end

    assign o_neg = r_neg[N-1];
    assign o_side = r_side[N-1];

endmodule

// ----- sv/gcd_dot.sv -----
// Law-of-cosines term, clamp to [-1,1] and radicand 1 - d^2 for the sine side.
// Three register stages, one multiply level each; depends on gcd_pkg.
module gcd_dot (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  gcd_pkg::t_trig                    i_cos [gcd_pkg::LANES],
    input  gcd_pkg::t_trig                    i_sin [gcd_pkg::LANES],
    input  logic                              i_neg,
    input  gcd_pkg::t_side                    i_side,
    output logic signed [gcd_pkg::DW-1:0]     o_d,
    output logic [gcd_pkg::VW-1:0]            o_v,
    output gcd_pkg::t_side                    o_side
);
    localparam int XW = gcd_pkg::XW;
    localparam int DW = gcd_pkg::DW;
    localparam int VW = gcd_pkg::VW;
    localparam int PW = 2 * XW;
    localparam int SW = XW + 1;
    localparam int MW = 2 * (DW - 1);
    localparam logic signed [PW-1:0] R30 = PW'(64'd1 << 29);
    localparam logic signed [SW-1:0] POS1 = SW'(gcd_pkg::ONE_Q30);
    localparam logic [MW-1:0] ONE_Q60 = MW'(64'd1 << 60);

    logic signed [PW-1:0] w_ss, w_cc, w_q;
    gcd_pkg::t_trig       w_qr;
    logic signed [SW-1:0] w_sum;
    logic [DW-2:0]        w_mag;
    logic [MW-1:0]        w_dd;

    gcd_pkg::t_trig              r_ss, r_cc, r_ct;
    logic signed [DW-1:0]        r_d, r_d3;
    logic [VW-1:0]               r_v;
    gcd_pkg::t_side              r_side1, r_side2, r_side3;

    always_comb begin
        w_ss = PW'(i_sin[gcd_pkg::LANE_LAT_A]) * PW'(i_sin[gcd_pkg::LANE_LAT_B]) + R30;
        w_cc = PW'(i_cos[gcd_pkg::LANE_LAT_A]) * PW'(i_cos[gcd_pkg::LANE_LAT_B]) + R30;
        w_q = PW'(r_cc) * PW'(r_ct) + R30;
        w_qr = XW'(w_q >>> 30);
        w_sum = SW'(r_ss) + SW'(w_qr);
        w_mag = r_d[DW-1] ? (DW-1)'(-r_d) : (DW-1)'(r_d);
        w_dd = MW'(w_mag) * MW'(w_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1 <= '0;
            r_side2 <= '0;
            r_side3 <= '0;
        end else if (i_en) begin
            r_side1 <= i_side;
            r_side2 <= r_side1;
            r_side3 <= r_side2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ss <= XW'(w_ss >>> 30);
            r_cc <= XW'(w_cc >>> 30);
            r_ct <= i_neg ? -i_cos[gcd_pkg::LANE_DLON] : i_cos[gcd_pkg::LANE_DLON];
            if (w_sum > POS1) begin
                r_d <= gcd_pkg::ONE_Q30;
            end else if (w_sum < -POS1) begin
                r_d <= -gcd_pkg::ONE_Q30;
            end else begin
                r_d <= DW'(w_sum);
            end
            r_d3 <= r_d;
            r_v <= VW'(ONE_Q60 - w_dd);
        end
    end

    assign o_d = r_d3;
    assign o_v = r_v;
    assign o_side = r_side3;

endmodule

// ----- sv/gcd_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Depends on gcd_pkg.
module gcd_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic signed [gcd_pkg::DW-1:0] i_d,
    input  logic [gcd_pkg::VW-1:0]        i_v,
    input  gcd_pkg::t_side                i_side,
    output logic signed [gcd_pkg::DW-1:0] o_d,
    output gcd_pkg::t_trig                o_y,
    output gcd_pkg::t_side                o_side
);
    localparam int S = gcd_pkg::SQ_STEPS;
    localparam int VW = gcd_pkg::VW;
    localparam int RW = gcd_pkg::RW;
    localparam int DW = gcd_pkg::DW;

    logic [VW-1:0]        r_v [S];
    logic [RW-1:0]        r_res [S];
    logic signed [DW-1:0] r_d [S];
    gcd_pkg::t_side       r_side [S];

    for (genvar s = 0; s < S; s++) begin : g_step
        localparam logic [RW-1:0] BIT = RW'(64'd1 << (2 * (S - 1 - s)));
        logic [VW-1:0]        w_v;
        logic [RW-1:0]        w_res, w_t;
        logic signed [DW-1:0] w_d;
        gcd_pkg::t_side       w_side;

        if (s == 0) begin : g_src
            always_comb begin
                w_v = i_v;
                w_res = '0;
                w_d = i_d;
                w_side = i_side;
            end
        end else begin : g_src
            always_comb begin
                w_v = r_v[s-1];
                w_res = r_res[s-1];
                w_d = r_d[s-1];
                w_side = r_side[s-1];
            end
        end

        assign w_t = w_res + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s] <= '0;
            end else if (i_en) begin
                r_side[s] <= w_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[s] <= w_d;
                if (RW'(w_v) >= w_t) begin
                    r_v[s] <= VW'(RW'(w_v) - w_t);
                    r_res[s] <= (w_res >> 1) + BIT;
                end else begin
                    r_v[s] <= w_v;
                    r_res[s] <= w_res >> 1;
                end
            end
        end
    end

    assign o_d = r_d[S-1];
    assign o_y = gcd_pkg::t_trig'(r_res[S-1]);
    assign o_side = r_side[S-1];

endmodule

// ----- sv/gcd_acos.sv -----
// Vectoring CORDIC for the central angle, then unit scaling, rounding, saturation and zeroing of out-of-range results.
// Ends in the output register; depends on gcd_pkg.
module gcd_acos #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic signed [gcd_pkg::DW-1:0]     i_d,
    input  gcd_pkg::t_trig                    i_y,
    input  gcd_pkg::t_side                    i_side,
    output logic                              o_valid,
    output logic [gcd_pkg::DIST_W-1:0]        o_dist_out,
    output logic                              o_coords_ok
);
    localparam int N = CORDIC_STAGES;
    localparam int XW = gcd_pkg::XW;
    localparam int ZW = gcd_pkg::ZW;
    localparam int FW = gcd_pkg::FW;
    localparam int DIST_W = gcd_pkg::DIST_W;
    localparam logic [63:0] RND40 = 64'd1 << 39;

    gcd_pkg::t_trig  w_x0, w_y0;
    gcd_pkg::t_angle w_z0;
    logic [31:0]     w_ang;
    logic [FW-1:0]   w_f;
    logic [63:0]     w_sum;
    logic [23:0]     w_q;

    gcd_pkg::t_trig    r_x [N+1];
    gcd_pkg::t_trig    r_y [N+1];
    gcd_pkg::t_angle   r_z [N+1];
    gcd_pkg::t_side    r_side [N+1];
    logic [63:0]       r_prod;
    gcd_pkg::t_side    r_side_m;
    logic [DIST_W-1:0] r_dist;
    gcd_pkg::t_side    r_side_o;

    always_comb begin
        if (i_d[gcd_pkg::DW-1]) begin
            w_x0 = i_y;
            w_y0 = -gcd_pkg::t_trig'(i_d);
            w_z0 = gcd_pkg::HALF_PI_Q30;
        end else begin
            w_x0 = gcd_pkg::t_trig'(i_d);
            w_y0 = i_y;
            w_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0] <= '0;
        end else if (i_en) begin
            r_side[0] <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= w_x0;
            r_y[0] <= w_y0;
            r_z[0] <= w_z0;
        end
    end

    for (genvar s = 1; s <= N; s++) begin : g_vec
        localparam gcd_pkg::t_angle ATAN = gcd_pkg::t_angle'(gcd_pkg::atan_q30(s - 1));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s] <= '0;
            end else if (i_en) begin
                r_side[s] <= r_side[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[s-1][XW-1] && (r_y[s-1] != '0)) begin
                    r_x[s] <= r_x[s-1] + (r_y[s-1] >>> (s - 1));
                    r_y[s] <= r_y[s-1] - (r_x[s-1] >>> (s - 1));
                    r_z[s] <= r_z[s-1] + ATAN;
                end else begin
                    r_x[s] <= r_x[s-1] - (r_y[s-1] >>> (s - 1));
                    r_y[s] <= r_y[s-1] + (r_x[s-1] >>> (s - 1));
                    r_z[s] <= r_z[s-1] - ATAN;
                end
            end
        end
    end

    always_comb begin
        w_ang = r_z[N][ZW-1] ? '0 : r_z[N][31:0];
        case (r_side[N].unit)
            gcd_pkg::UNIT_KM: w_f = FW'(gcd_pkg::F_KM);
            gcd_pkg::UNIT_NM: w_f = FW'(gcd_pkg::F_NM);
            default:          w_f = FW'(gcd_pkg::F_MI);
        endcase
        w_sum = r_prod + RND40;
        w_q = w_sum[63:40];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_m <= '0;
            r_side_o <= '0;
        end else if (i_en) begin
            r_side_m <= r_side[N];
            r_side_o <= r_side_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 64'(w_ang) * 64'(w_f);
            if (!r_side_m.ok) begin
                r_dist <= '0;
            end else if (w_q > 24'(gcd_pkg::DIST_MAX)) begin
                r_dist <= gcd_pkg::DIST_MAX;
            end else begin
                r_dist <= w_q[DIST_W-1:0];
            end
        end
    end

    assign o_valid = r_side_o.vld;
    assign o_dist_out = r_dist;
    assign o_coords_ok = r_side_o.ok;

endmodule

// ----- sv/great_circle_distance_core.sv -----
// Great-circle distance core: spherical law of cosines on two positions, fully pipelined.
// Top level; instantiates gcd_front, gcd_trig, gcd_dot, gcd_sqrt and gcd_acos; uses gcd_pkg.
//
// One position pair enters per clock while o_stall is low; its distance then passes through
// two input stages, the sin/cos CORDIC, three product stages, a 31-stage square root and
// the acos CORDIC with two scaling stages. Every stage advances together; o_stall rises
// only while a result sits in the output register and i_stall holds it there, and then
// the whole pipeline holds with nothing lost.
module great_circle_distance_core #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [gcd_pkg::CW-1:0]     i_lat_a,
    input  logic signed [gcd_pkg::CW-1:0]     i_lon_a,
    input  logic signed [gcd_pkg::CW-1:0]     i_lat_b,
    input  logic signed [gcd_pkg::CW-1:0]     i_lon_b,
    input  logic [1:0]                        i_unit_sel,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [gcd_pkg::DIST_W-1:0]        o_dist_out,
    output logic                              o_coords_ok
);
    logic                          w_en;
    gcd_pkg::t_angle               w_z [gcd_pkg::LANES];
    logic                          w_neg_f, w_neg_t;
    gcd_pkg::t_side                w_side_f, w_side_t, w_side_d, w_side_s;
    gcd_pkg::t_trig                w_cos [gcd_pkg::LANES];
    gcd_pkg::t_trig                w_sin [gcd_pkg::LANES];
    logic signed [gcd_pkg::DW-1:0] w_d, w_d_s;
    logic [gcd_pkg::VW-1:0]        w_v;
    gcd_pkg::t_trig                w_y;

    assign w_en = !(o_valid && i_stall);
    assign o_stall = !w_en;

    gcd_front #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid),
        .i_lat_a(i_lat_a), .i_lon_a(i_lon_a), .i_lat_b(i_lat_b), .i_lon_b(i_lon_b),
        .i_unit_sel(i_unit_sel), .o_z(w_z), .o_neg(w_neg_f), .o_side(w_side_f)
    );

    gcd_trig #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_trig (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_z(w_z), .i_neg(w_neg_f),
        .i_side(w_side_f), .o_cos(w_cos), .o_sin(w_sin), .o_neg(w_neg_t), .o_side(w_side_t)
    );

    gcd_dot u_dot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_cos(w_cos), .i_sin(w_sin),
        .i_neg(w_neg_t), .i_side(w_side_t), .o_d(w_d), .o_v(w_v), .o_side(w_side_d)
    );

    gcd_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(w_d), .i_v(w_v),
        .i_side(w_side_d), .o_d(w_d_s), .o_y(w_y), .o_side(w_side_s)
    );

    gcd_acos #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_acos (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(w_d_s), .i_y(w_y),
        .i_side(w_side_s), .o_valid(o_valid), .o_dist_out(o_dist_out),
        .o_coords_ok(o_coords_ok)
    );

endmodule

// ----- sv/gcd_chk.sv -----
// Port-level checker for great_circle_distance_core, attached by the bind below.
// Depends only on the top level's ports and gcd_pkg widths.
module gcd_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [gcd_pkg::DIST_W-1:0] o_dist_out,
    input logic                       o_coords_ok
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dist_out) && $stable(o_coords_ok))
        else $error("output transfer changed while stalled");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_coords_ok |-> o_dist_out == '0)
        else $error("out-of-range result carries a distance");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stalled without a blocked output");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !$past(i_valid, 1) && $past(i_rst_n, 1) |-> !o_stall)
        else $error("stall while output drains");

endmodule

bind great_circle_distance_core gcd_chk u_chk (.*);

// ----- verif/great_circle_distance_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for great_circle_distance_core: directed and random position pairs.
// Computes each expected distance in fixed point and checks results in order; uses gcd_pkg.
module great_circle_distance_core_test;

    localparam int  FRAC      = 16;
    localparam int  STAGES    = 24;
    localparam int  LATENCY   = 2 * STAGES + 39;
    localparam int  LIMIT     = 600000;
    localparam longint ONE_DEG = longint'(1) << FRAC;
    localparam longint DEG90   = 90 * ONE_DEG;
    localparam longint DEG180  = 180 * ONE_DEG;
    localparam longint Q30_ONE = longint'(1) << 30;
    localparam longint PI_Q60L = 64'h3243F6A8885A308D;
    localparam logic [1:0] UNIT_MI = 2'd0;
    localparam logic [1:0] UNIT_MI_ALT = 2'd3;

    typedef struct packed {
        logic [gcd_pkg::DIST_W-1:0] dist_q;
        logic                       ok;
    } t_leg;

    logic i_clk, i_rst_n, i_valid, i_stall, o_stall, o_valid, o_coords_ok;
    logic signed [gcd_pkg::CW-1:0] i_lat_a, i_lon_a, i_lat_b, i_lon_b;
    logic [1:0] i_unit_sel;
    logic [gcd_pkg::DIST_W-1:0] o_dist_out;

    t_leg   leg_queue[$];
    longint arctan_tab[STAGES];
    int     mismatches = 0;
    int     cycles = 0;
    bit     quiet = 0;
    int     stall_left = 0;

    great_circle_distance_core dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint shr_round(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint arctan_step(int i);
        longint acc;
        bit     neg;
        acc = 0;
        neg = 0;
        if (i == 0)
            return (PI_Q60L + (longint'(1) << 31)) >>> 32;
        for (int n = 1; i * n <= 62; n += 2) begin
            acc = neg ? acc - ((longint'(1) << (62 - i * n)) / n)
                      : acc + ((longint'(1) << (62 - i * n)) / n);
            neg = !neg;
        end
        return (acc + (longint'(1) << 31)) >>> 32;
    endfunction

    function automatic void rotate(longint z, output longint c, output longint s);
        longint x, y, dx, dy;
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_tab[i];
            end else begin
                x += dx; y -= dy; z += arctan_tab[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_leg distance_of(longint la, longint oa, longint lb, longint ob,
                                         logic [1:0] unit);
        t_leg r;
        longint pi30, c36, sa, ca, sb, cb, ct, st, t, d, x, y, z, dx, dy, tmp;
        longint unsigned den, f, dist_v;
        bit neg;
        pi30 = (PI_Q60L + (longint'(1) << 29)) >>> 30;
        c36  = (PI_Q60L / 180 + (longint'(1) << 23)) >>> 24;
        r = '0;
        if (la > DEG90 || la < -DEG90 || lb > DEG90 || lb < -DEG90 ||
            oa > DEG180 || oa < -DEG180 || ob > DEG180 || ob < -DEG180)
            return r;
        rotate(shr_round(la * c36, FRAC + 6), ca, sa);
        rotate(shr_round(lb * c36, FRAC + 6), cb, sb);
        t = oa - ob;
        if (t < 0) t = -t;
        if (t > DEG180) t = 2 * DEG180 - t;
        neg = 0;
        if (t > DEG90) begin
            t = DEG180 - t; neg = 1;
        end
        rotate(shr_round(t * c36, FRAC + 6), ct, st);
        if (neg) ct = -ct;
        d = shr_round(sa * sb, 30) + shr_round(shr_round(ca * cb, 30) * ct, 30);
        if (d > Q30_ONE) d = Q30_ONE;
        if (d < -Q30_ONE) d = -Q30_ONE;
        tmp = d < 0 ? -d : d;
        y = longint'(int_sqrt((64'd1 << 60) - longint'(tmp * tmp)));
        x = d;
        z = 0;
        if (x < 0) begin
            x = y; y = -d; z = pi30 >>> 1;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += arctan_tab[i];
            end else begin
                x -= dx; y += dy; z -= arctan_tab[i];
            end
        end
        if (z < 0) z = 0;
        den = 5 * longint'(pi30);
        f = ((64'd62181 << 48) + den / 2) / den;
        if (unit == gcd_pkg::UNIT_KM) f = (f * 64'd1609344 + 64'd500000) / 64'd1000000;
        else if (unit == gcd_pkg::UNIT_NM) f = (f * 64'd8684 + 64'd5000) / 64'd10000;
        dist_v = (longint'(z) * f + (64'd1 << 39)) >> 40;
        if (dist_v > 64'd8388607) dist_v = 64'd8388607;
        r.dist_q = dist_v[gcd_pkg::DIST_W-1:0];
        r.ok     = 1'b1;
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    task automatic send_pair(longint la, longint oa, longint lb, longint ob, logic [1:0] u);
        bit taken;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_lat_a    <= la[gcd_pkg::CW-1:0];
        i_lon_a    <= oa[gcd_pkg::CW-1:0];
        i_lat_b    <= lb[gcd_pkg::CW-1:0];
        i_lon_b    <= ob[gcd_pkg::CW-1:0];
        i_unit_sel <= u;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        leg_queue.push_back(distance_of(la, oa, lb, ob, u));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (leg_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic longint rand_in(longint span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic longint rand_field();
        return longint'($urandom_range(0, 32'h1FFFFFF)) - 32'h1000000;
    endfunction

    task automatic test_bounds();
        longint lim[6] = '{DEG90, -DEG90, DEG180, -DEG180, 16777215, -16777216};
        send_pair(DEG90, DEG180, -DEG90, -DEG180, UNIT_MI);
        send_pair(-DEG90, -DEG180, DEG90, DEG180, gcd_pkg::UNIT_KM);
        send_pair(DEG90 + 1, 0, 0, 0, UNIT_MI);
        send_pair(0, 0, -DEG90 - 1, 0, UNIT_MI);
        send_pair(0, DEG180 + 1, 0, 0, UNIT_MI);
        send_pair(0, 0, 0, -DEG180 - 1, UNIT_MI);
        foreach (lim[k]) send_pair(lim[k], lim[5 - k], lim[(k + 2) % 6], lim[k], 2'(k));
    endtask

    task automatic test_special();
        send_pair(0, 0, 0, 0, UNIT_MI);
        send_pair(12345678, -3000000, 12345678, -3000000, gcd_pkg::UNIT_NM);
        send_pair(0, 0, 0, DEG180, UNIT_MI);
        send_pair(0, 0, 0, -DEG180, gcd_pkg::UNIT_KM);
        send_pair(DEG90 / 2, DEG90, -DEG90 / 2, -DEG90, gcd_pkg::UNIT_NM);
        send_pair(1000000, DEG180 - 5, -2000000, -DEG180 + 5, UNIT_MI_ALT);
        send_pair(3000000, 100, 3000000, DEG90 + 200000, UNIT_MI);
        send_pair(-3000000, 7, 2500000, DEG90 - 3, UNIT_MI_ALT);
        for (int u = 0; u < 4; u++) send_pair(2000000, 1000000, -1500000, -9000000, 2'(u));
        drain();
    endtask

    task automatic test_random(int n);
        longint la, oa, lb, ob;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                la = rand_field(); oa = rand_field(); lb = rand_field(); ob = rand_field();
            end else begin
                la = rand_in(DEG90); oa = rand_in(DEG180);
                lb = rand_in(DEG90); ob = rand_in(DEG180);
                if ($urandom_range(0, 7) == 0) begin
                    lb = la + $urandom_range(0, 200) - 100;
                    ob = oa + $urandom_range(0, 200) - 100;
                    if (lb > DEG90 || lb < -DEG90) lb = la;
                end
            end
            send_pair(la, oa, lb, ob, 2'($urandom_range(0, 3)));
            if (k == n / 2) drain();
        end
    endtask

    // hold the output side in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 13);
            i_stall <= 1'b1;
        end else
            i_stall <= 1'b0;
    end

    always @(negedge i_clk) begin
        t_leg want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (leg_queue.size() == 0)
                report("unexpected transfer", o_dist_out, -1);
            else begin
                want = leg_queue.pop_front();
                if (o_dist_out !== want.dist_q) report("dist_out", o_dist_out, want.dist_q);
                if (o_coords_ok !== want.ok) report("coords_ok", o_coords_ok, want.ok);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 0; i_valid = 0; i_stall = 0; i_unit_sel = 0;
        i_lat_a = 0; i_lon_a = 0; i_lat_b = 0; i_lon_b = 0;
        for (int i = 0; i < STAGES; i++) arctan_tab[i] = arctan_step(i);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bounds();
        test_special();
        test_random(1200);
        quiet = 1;
        test_random(300);
        drain();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
